// File: rtl/vspc_pkg.sv
// ----------------------------------------------------------------------------
// vspc_pkg
// Shared constants, register map and the sRGB encoding table of the volume
// slice pixel converter.
// ----------------------------------------------------------------------------
package vspc_pkg;

  localparam int unsigned MAX_EXTENT = 4096;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MARG_X = 3'd2;
  localparam logic [2:0] REG_MARG_Y = 3'd3;
  localparam logic [2:0] REG_MAXVAL = 3'd4;
  localparam logic [2:0] REG_MODE   = 3'd5;
  localparam logic [2:0] REG_FORMAT = 3'd6;

  localparam logic [2:0] FMT_BYTE  = 3'd0;
  localparam logic [2:0] FMT_U16   = 3'd1;
  localparam logic [2:0] FMT_BGR   = 3'd2;
  localparam logic [2:0] FMT_VEC2  = 3'd3;
  localparam logic [2:0] FMT_VEC3  = 3'd4;

  localparam int MODE_CYL  = 0;
  localparam int MODE_NORM = 1;
  localparam int MODE_GAM  = 2;
  localparam int MODE_INV  = 3;
  localparam int MODE_BIN  = 4;
  localparam int MODE_SQD  = 5;

  localparam logic [15:0] FACTOR_BIG = 16'hFF00;
  localparam logic [15:0] FACTOR_LIM = 16'h8000;
  localparam logic [7:0]  BYTE_FULL  = 8'hFF;

  typedef logic [7:0] srgb_tab_t [256];

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  function automatic logic [255:0] pow256(input logic [255:0] base, input int n);
    logic [255:0] acc;
    acc = 256'd1;
    for (int k = 0; k < n; k++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  function automatic srgb_tab_t build_srgb();
    srgb_tab_t  tab;
    logic [255:0] lhs;
    logic [255:0] rhs;
    logic [255:0] p255;
    logic [255:0] c12;
    int s;
    int done;
    p255 = pow256(256'd255, 5);
    c12 = pow256(256'd10761, 12);
    s = 0;
    tab[0] = 8'd0;
    for (int i = 1; i < 256; i++) begin
      lhs = pow256(256'(i), 5) * c12;
      done = 0;
      for (int k = 0; k < 256; k++) begin
        if (done == 0 && s < 255) begin
          rhs = p255 * pow256(256'(40 * (s + 1) + 541), 12);
          if (lhs >= rhs) begin
            s = s + 1;
          end else begin
            done = 1;
          end
        end
      end
      tab[i] = 8'(s);
    end
    return tab;
  endfunction

  localparam srgb_tab_t SRGB = build_srgb();

endpackage

// File: rtl/volume_slice_pixel_convert_unit.sv
// ----------------------------------------------------------------------------
// volume_slice_pixel_convert_unit
// Converts one voxel into one BGRA pixel. Takes an item every cycle and
// delivers its pixel with done; busy never rises. The depth is set by the
// input register, the bit-serial square root (9 stages), the scaling
// register, the bit-serial scaling divider (9 stages) and the output
// register. The receiver cannot stall, so no result is ever held back.
// Write configuration only while no item is in flight.
// ----------------------------------------------------------------------------
module volume_slice_pixel_convert_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  logic [15:0] chan_a,
  input  logic [15:0] chan_b,
  input  logic [15:0] chan_c,
  output logic        done,
  output logic [7:0]  blue,
  output logic [7:0]  green,
  output logic [7:0]  red,
  output logic [7:0]  alpha,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vspc_pkg::*;

  localparam int SIDE_LAT = 19;
  localparam int MASK_LAT = 3;

  logic [12:0] slice_width;
  logic [12:0] slice_height;
  logic [10:0] margin_x;
  logic [10:0] margin_y;
  logic [15:0] max_value;
  logic [5:0]  mode_flags;
  logic [2:0]  sample_format;

  logic        vld_q  [0:SIDE_LAT];
  color_t      side_q [0:SIDE_LAT];
  logic        out_q  [MASK_LAT:SIDE_LAT];
  logic [11:0] col_q;
  logic [11:0] row_q;
  logic [15:0] a_q;
  color_t      side0;
  logic [15:0] samp;
  logic [15:0] samp_s;
  logic [15:0] mx_s;
  logic [23:0] num;
  logic [15:0] den;
  logic [15:0] f;
  logic [7:0]  lin0;
  logic [7:0]  lin;
  logic        outside;

  assign busy = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_width <= 13'd1;
      slice_height <= 13'd1;
      margin_x <= 11'd0;
      margin_y <= 11'd0;
      max_value <= 16'd255;
      mode_flags <= 6'd0;
      sample_format <= FMT_BYTE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_WIDTH:  slice_width <= pwdata[12:0];
        REG_HEIGHT: slice_height <= pwdata[12:0];
        REG_MARG_X: margin_x <= pwdata[10:0];
        REG_MARG_Y: margin_y <= pwdata[10:0];
        REG_MAXVAL: max_value <= pwdata[15:0];
        REG_MODE:   mode_flags <= pwdata[5:0];
        REG_FORMAT: sample_format <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WIDTH:  prdata = {19'd0, slice_width};
      REG_HEIGHT: prdata = {19'd0, slice_height};
      REG_MARG_X: prdata = {21'd0, margin_x};
      REG_MARG_Y: prdata = {21'd0, margin_y};
      REG_MAXVAL: prdata = {16'd0, max_value};
      REG_MODE:   prdata = {26'd0, mode_flags};
      REG_FORMAT: prdata = {29'd0, sample_format};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    col_q <= col;
    row_q <= row;
    a_q <= chan_a;
  end

  function automatic logic [7:0] halve(input logic [15:0] raw);
    logic [15:0] t;
    t = raw + {15'd0, raw[15]};
    return t[8:1];
  endfunction

  always_comb begin
    side0.blue = 8'd0;
    side0.green = 8'd0;
    side0.red = 8'd0;
    if (sample_format == FMT_BGR) begin
      side0 = '{blue: chan_a[7:0], green: chan_b[7:0], red: chan_c[7:0]};
    end else if (sample_format == FMT_VEC2 || sample_format == FMT_VEC3) begin
      side0.blue = halve(chan_a);
      side0.green = halve(chan_b);
      side0.red = (sample_format == FMT_VEC3) ? halve(chan_c) : 8'd0;
    end
    samp = (sample_format == FMT_BYTE) ? {8'd0, a_q[7:0]} : a_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= start;
    end
    side_q[0] <= side0;
  end

  for (genvar k = 1; k <= SIDE_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
      side_q[k] <= side_q[k-1];
    end
  end

  vspc_mask u_mask (
    .clk          (clk),
    .col          (col_q),
    .row          (row_q),
    .slice_width  (slice_width),
    .slice_height (slice_height),
    .margin_x     (margin_x),
    .margin_y     (margin_y),
    .outside      (outside)
  );

  assign out_q[MASK_LAT] = outside && mode_flags[MODE_CYL];

  for (genvar k = MASK_LAT + 1; k <= SIDE_LAT; k++) begin : g_out
    always_ff @(posedge clk) begin
      out_q[k] <= out_q[k-1];
    end
  end

  vspc_sqrt u_sqrt_samp (
    .clk (clk),
    .en  (mode_flags[MODE_SQD]),
    .val (samp),
    .res (samp_s)
  );

  vspc_sqrt u_sqrt_max (
    .clk (clk),
    .en  (mode_flags[MODE_SQD]),
    .val (max_value),
    .res (mx_s)
  );

  always_comb begin
    f = mode_flags[MODE_NORM] ? mx_s : {8'd0, BYTE_FULL};
    if (!mode_flags[MODE_NORM] && mx_s > FACTOR_LIM) begin
      f = FACTOR_BIG;
    end
    if (f == 16'd0) begin
      f = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    num <= {samp_s, 8'd0} - {8'd0, samp_s};
    den <= f;
  end

  vspc_div u_div (
    .clk (clk),
    .num (num),
    .den (den),
    .quo (lin0)
  );

  always_comb begin
    lin = lin0;
    if (mode_flags[MODE_BIN]) begin
      lin = (lin != 8'd0) ? BYTE_FULL : 8'd0;
    end
    if (mode_flags[MODE_INV]) begin
      lin = BYTE_FULL - lin;
    end
    if (mode_flags[MODE_GAM]) begin
      lin = SRGB[lin];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_q[SIDE_LAT];
    end
    alpha <= BYTE_FULL;
    if (out_q[SIDE_LAT]) begin
      blue <= mode_flags[MODE_INV] ? BYTE_FULL : 8'd0;
      green <= mode_flags[MODE_INV] ? BYTE_FULL : 8'd0;
      red <= mode_flags[MODE_INV] ? BYTE_FULL : 8'd0;
      alpha <= mode_flags[MODE_INV] ? 8'd0 : BYTE_FULL;
    end else if (sample_format == FMT_BYTE || sample_format == FMT_U16) begin
      blue <= lin;
      green <= lin;
      red <= lin;
    end else begin
      blue <= side_q[SIDE_LAT].blue;
      green <= side_q[SIDE_LAT].green;
      red <= side_q[SIDE_LAT].red;
    end
  end

endmodule

// File: rtl/vspc_mask.sv
// ----------------------------------------------------------------------------
// vspc_mask
// Three-stage cylinder test: offsets, squares and limit product, compare.
// ----------------------------------------------------------------------------
module vspc_mask (
  input  logic        clk,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  logic [12:0] slice_width,
  input  logic [12:0] slice_height,
  input  logic [10:0] margin_x,
  input  logic [10:0] margin_y,
  output logic        outside
);
  import vspc_pkg::*;

  logic [12:0]        w_clip;
  logic [12:0]        h_clip;
  logic signed [13:0] w1;
  logic signed [13:0] h1;
  logic signed [14:0] dx;
  logic signed [14:0] dy;
  logic signed [14:0] lx;
  logic signed [14:0] ly;
  logic signed [29:0] sqx;
  logic signed [29:0] sqy;
  logic signed [29:0] lim;
  logic [30:0]        sum;

  always_comb begin
    w_clip = (slice_width > 13'(MAX_EXTENT)) ? 13'(MAX_EXTENT) : slice_width;
    h_clip = (slice_height > 13'(MAX_EXTENT)) ? 13'(MAX_EXTENT) : slice_height;
    w1 = $signed({1'b0, w_clip}) - 14'sd1;
    h1 = $signed({1'b0, h_clip}) - 14'sd1;
    sum = {1'b0, sqx} + {1'b0, sqy};
  end

  always_ff @(posedge clk) begin
    dx <= $signed({2'b0, col, 1'b0}) - 15'(w1);
    dy <= $signed({2'b0, row, 1'b0}) - 15'(h1);
    lx <= 15'(w1) - $signed({3'b0, margin_x, 1'b0});
    ly <= 15'(h1) - $signed({3'b0, margin_y, 1'b0});
    sqx <= dx * dx;
    sqy <= dy * dy;
    lim <= lx * ly;
    outside <= $signed({1'b0, sum}) > 32'(lim);
  end

endmodule

// File: rtl/vspc_sqrt.sv
// ----------------------------------------------------------------------------
// vspc_sqrt
// Rounded square root, one root bit per stage, rounding in a final stage.
// Passes the operand through unchanged when disabled.
// ----------------------------------------------------------------------------
module vspc_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] val,
  output logic [15:0] res
);

  logic [10:0] rem_q  [0:8];
  logic [7:0]  root_q [0:8];
  logic [15:0] raw_q  [0:8];
  logic        en_q   [0:8];
  logic [8:0]  rounded;

  assign rem_q[0]  = 11'd0;
  assign root_q[0] = 8'd0;
  assign raw_q[0]  = val;
  assign en_q[0]   = en;

  for (genvar k = 0; k < 8; k++) begin : g_step
    logic [10:0] cur;
    logic [10:0] trial;
    logic        ge;
    always_comb begin
      cur = {rem_q[k][8:0], raw_q[k][15-2*k -: 2]};
      trial = {1'b0, root_q[k], 2'b01};
      ge = cur >= trial;
    end
    always_ff @(posedge clk) begin
      rem_q[k+1] <= ge ? cur - trial : cur;
      root_q[k+1] <= {root_q[k][6:0], ge};
      raw_q[k+1] <= raw_q[k];
      en_q[k+1] <= en_q[k];
    end
  end

  assign rounded = {1'b0, root_q[8]} + 9'(rem_q[8] > {3'b0, root_q[8]});

  always_ff @(posedge clk) begin
    res <= en_q[8] ? {7'b0, rounded} : raw_q[8];
  end

endmodule

// File: rtl/vspc_div.sv
// ----------------------------------------------------------------------------
// vspc_div
// Saturating 8-bit quotient of a 24-bit numerator by a 16-bit factor,
// overflow check first, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module vspc_div (
  input  logic        clk,
  input  logic [23:0] num,
  input  logic [15:0] den,
  output logic [7:0]  quo
);

  logic [23:0] rem_q [0:8];
  logic [15:0] den_q [0:8];
  logic [7:0]  q_q   [0:8];
  logic        sat_q [0:8];

  always_ff @(posedge clk) begin
    rem_q[0] <= num;
    den_q[0] <= den;
    q_q[0]   <= 8'd0;
    sat_q[0] <= num >= {den, 8'd0};
  end

  for (genvar k = 0; k < 8; k++) begin : g_bit
    logic [23:0] trial;
    logic        ge;
    always_comb begin
      trial = {8'd0, den_q[k]} << (7 - k);
      ge = rem_q[k] >= trial;
    end
    always_ff @(posedge clk) begin
      rem_q[k+1] <= ge ? rem_q[k] - trial : rem_q[k];
      den_q[k+1] <= den_q[k];
      q_q[k+1] <= {q_q[k][6:0], ge};
      sat_q[k+1] <= sat_q[k];
    end
  end

  assign quo = sat_q[8] ? 8'hFF : q_q[8];

endmodule
